[src/blzd_pkg.sv]
// Package for the backward LZSS decoder: shared types, constants and defaults.
// No dependencies; every module file in src imports it.
package blzd_pkg;

  localparam int HISTORY_DEPTH_DEF = 8192;
  localparam int CMDQ_DEPTH_DEF    = 4;

  localparam int LEN_BIAS  = 3;
  localparam int DIST_BIAS = 3;
  localparam int TOKENS_PER_FLAG = 8;
  localparam int DIST_W = 13;

  typedef enum logic {
    CMD_LIT,
    CMD_COPY
  } cmd_kind_t;

  // One decoded token handed from the front part to the back part.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  hi;
    logic [7:0]  lo;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EMIT
  } back_state_t;

endpackage

[src/blzd_ifs.sv]
// Stream interfaces of the backward LZSS decoder: compressed input, decompressed output.
// Depends on nothing; each carries valid, ready and the payload.
interface blzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface blzd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

[src/backward_lzss_decoder_core.sv]
// Top level of the backward LZSS decoder: front part, token queue, back part.
// Depends on blzd_pkg, blzd_ifs, blzd_front, blzd_cmdq and blzd_back.
//
//   Channel  Role    Payload                     Handshake
//   comp     sink    in_byte[7:0], last_byte      valid/ready
//   decomp   source  out_byte[7:0], last_of_run   valid/ready
//
// The front takes one compressed byte per cycle while the token queue has room.
// A literal leaves the back part straight from idle; a copy is loaded first and then
// takes a history read and then a write and output step per byte, 3 to 18 bytes.
// Flag bytes and pair high bytes produce no token; only the front handles them.
// Reset (rst, synchronous) clears token state and pointers; history is not cleared.
// A stalled output holds the back part; a full queue holds the input.
module backward_lzss_decoder_core
  import blzd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int CMDQ_DEPTH    = CMDQ_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  blzd_in_if.sink    comp,
  blzd_out_if.source decomp
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  blzd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .comp   (comp),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  blzd_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  blzd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .decomp (decomp)
  );

endmodule

[src/blzd_front.sv]
// Front part: accepts compressed bytes, tracks flag and pair state, issues tokens.
// Depends on blzd_pkg and blzd_in_if.
module blzd_front
  import blzd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  blzd_in_if.sink      comp,
  input  logic         q_full,
  output logic         push,
  output cmd_t         cmd
);

  logic [7:0] flag_bits;
  logic [3:0] tokens_left;
  logic [7:0] pair_high;
  logic       awaiting_pair_low;
  logic       accept;

  assign comp.ready = !q_full;
  assign accept = comp.valid && comp.ready;

  always_comb begin
    push     = 1'b0;
    cmd.kind = CMD_LIT;
    cmd.hi   = pair_high;
    cmd.lo   = comp.in_byte;
    if (accept) begin
      if (awaiting_pair_low) begin
        push     = 1'b1;
        cmd.kind = CMD_COPY;
      end else if (tokens_left != 4'd0 && !flag_bits[7]) begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_bits         <= 8'd0;
      tokens_left       <= 4'd0;
      pair_high         <= 8'd0;
      awaiting_pair_low <= 1'b0;
    end else if (accept) begin
      if (comp.last_byte) begin
        flag_bits         <= 8'd0;
        tokens_left       <= 4'd0;
        pair_high         <= 8'd0;
        awaiting_pair_low <= 1'b0;
      end else if (awaiting_pair_low) begin
        awaiting_pair_low <= 1'b0;
        flag_bits         <= {flag_bits[6:0], 1'b0};
        if (tokens_left != 4'd0) begin
          tokens_left <= tokens_left - 4'd1;
        end
      end else if (tokens_left == 4'd0) begin
        flag_bits   <= comp.in_byte;
        tokens_left <= 4'(TOKENS_PER_FLAG);
      end else if (flag_bits[7]) begin
        pair_high         <= comp.in_byte;
        awaiting_pair_low <= 1'b1;
      end else begin
        flag_bits   <= {flag_bits[6:0], 1'b0};
        tokens_left <= tokens_left - 4'd1;
      end
    end
  end

endmodule

[src/blzd_cmdq.sv]
// Short token queue between the front and back parts.
// Depends on blzd_pkg.
module blzd_cmdq
  import blzd_pkg::*;
#(
  parameter int DEPTH = CMDQ_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == CNT_W'(0));
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("token queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("token queue read while empty");

endmodule

[src/blzd_back.sv]
// Back part: carries out literal and copy tokens against the history memory.
// Depends on blzd_pkg and blzd_out_if.
module blzd_back
  import blzd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        empty,
  output logic        pop,
  blzd_out_if.source  decomp
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);

  back_state_t      state;
  back_state_t      state_next;
  logic [7:0]       hist [HISTORY_DEPTH];
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] src_addr;
  logic [PTR_W:0]   ptr_ext;
  logic [PTR_W:0]   dist_ext;
  logic [DIST_W-1:0] copy_dist;
  logic [4:0]       rem;
  logic [7:0]       rd_data;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             last_of_run;
  logic             slot_free;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic             load;
  logic             rd_en;

  assign slot_free = !out_valid || decomp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_byte  = head.lo;
    emit_last  = 1'b1;
    load       = 1'b0;
    rd_en      = 1'b0;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          if (head.kind == CMD_COPY) begin
            pop        = 1'b1;
            load       = 1'b1;
            state_next = B_READ;
          end else if (slot_free) begin
            pop  = 1'b1;
            emit = 1'b1;
          end
        end
      end
      B_READ: begin
        rd_en      = 1'b1;
        state_next = B_EMIT;
      end
      B_EMIT: begin
        emit_byte = rd_data;
        emit_last = (rem == 5'd0);
        if (slot_free) begin
          emit       = 1'b1;
          state_next = (rem == 5'd0) ? B_IDLE : B_READ;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Source slot is the write slot moved back by the distance, wrapped into the ring.
  always_comb begin
    ptr_ext  = {1'b0, ptr};
    dist_ext = (PTR_W + 1)'(copy_dist);
    if (ptr_ext >= dist_ext) begin
      src_addr = PTR_W'(ptr_ext - dist_ext);
    end else begin
      src_addr = PTR_W'(ptr_ext + (PTR_W + 1)'(HISTORY_DEPTH) - dist_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hist[ptr] <= emit_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= hist[src_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem       <= {1'b0, head.hi[7:4]} + 5'(LEN_BIAS - 1);
      copy_dist <= {1'b0, head.hi[3:0], head.lo} + DIST_W'(DIST_BIAS);
    end else if (emit && state == B_EMIT) begin
      rem <= rem - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        ptr       <= (ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
        out_valid <= 1'b1;
      end else if (decomp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= emit_byte;
      last_of_run <= emit_last;
    end
  end

  assign decomp.valid       = out_valid;
  assign decomp.out_byte    = out_byte;
  assign decomp.last_of_run = last_of_run;

  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == B_READ) |=> (state == B_EMIT))
    else $error("history read not followed by emit step");
  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_W'(HISTORY_DEPTH - 1))
    else $error("history write slot out of range");

endmodule
